/* rtl/rtcl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcl_pkg: shared types and constants of the cartridge real-time clock
// Operation codes, register slots, the pipeline beat type and the small
// constant-modulus reductions used when loading the counters.
// ----------------------------------------------------------------------------
package rtcl_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LATCH = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // register slots picked by select bits 2..0
    localparam logic [2:0] REG_SEC    = 3'd0;
    localparam logic [2:0] REG_MIN    = 3'd1;
    localparam logic [2:0] REG_HOUR   = 3'd2;
    localparam logic [2:0] REG_DAY_LO = 3'd3;
    localparam logic [2:0] REG_DAY_HI = 3'd4;

    localparam int          SEL_CLOCK_BIT  = 3;
    localparam logic [7:0]  TPS_RESET      = 8'd60;
    localparam logic [7:0]  FILLER         = 8'hFF;
    localparam logic [5:0]  SEC_LAST       = 6'd59;
    localparam logic [5:0]  MIN_LAST       = 6'd59;
    localparam logic [4:0]  HOUR_LAST      = 5'd23;
    localparam logic [8:0]  DAY_LAST       = 9'd511;

    typedef struct packed {
        logic       valid;
        t_op        op;
        logic [3:0] sel;
        logic [7:0] data;
    } t_stage;

    // byte mod 60 by three conditional subtractions
    function automatic logic [5:0] mod60(input logic [7:0] d);
        logic [7:0] v;
        v = d;
        if (v >= 8'd240) v = v - 8'd240;
        if (v >= 8'd120) v = v - 8'd120;
        if (v >= 8'd60)  v = v - 8'd60;
        return v[5:0];
    endfunction

    // byte mod 24 by four conditional subtractions
    function automatic logic [4:0] mod24(input logic [7:0] d);
        logic [7:0] v;
        v = d;
        if (v >= 8'd192) v = v - 8'd192;
        if (v >= 8'd96)  v = v - 8'd96;
        if (v >= 8'd48)  v = v - 8'd48;
        if (v >= 8'd24)  v = v - 8'd24;
        return v[4:0];
    endfunction

endpackage

/* rtl/rtcl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcl_in_if: request channel of the real-time clock
// Carries one access beat: operation, bank select and data byte.
// ----------------------------------------------------------------------------
interface rtcl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [3:0] select;
    logic [7:0] data;

    modport source (output valid, output op, output select, output data, input ready);
    modport sink   (input valid, input op, input select, input data, output ready);
endinterface

/* rtl/rtcl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcl_out_if: read response channel of the real-time clock
// Carries the shadow register byte returned for a read.
// ----------------------------------------------------------------------------
interface rtcl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

/* rtl/rtc_counter_with_latch_registers_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_counter_with_latch_registers_top: cartridge real-time clock
// Sub-second tick counter cascading into seconds, minutes, hours and a
// 9-bit day count, with latched shadow registers for reads.
//
//   channel    dir  handshake      payload
//   i_item     in   valid/ready    op[1:0], select[3:0], data[7:0]
//   o_result   out  valid/ready    read_data[7:0] (reads only)
//   i_cfg_*    in   write enable   ticks per second [7:0]
//
// One beat per cycle is accepted while no read stalls; a beat passes the input
// register and is executed from there, and a read answer is then offered from
// the response register. Only the response register can stall: a read waits in
// the input register while a prior answer is untaken. Reset is synchronous and
// clears all counters, shadows and the tick rate to 60.
// ----------------------------------------------------------------------------
module rtc_counter_with_latch_registers_top
    import rtcl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    rtcl_in_if.sink       i_item,
    rtcl_out_if.source    o_result
);

    logic [7:0] r_tps;
    t_stage     stage;
    logic       exec;

    // hold tick rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_data;
        end
    end

    rtcl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_exec  (exec),
        .o_stage (stage)
    );

    rtcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tps    (r_tps),
        .i_stage  (stage),
        .o_exec   (exec),
        .o_result (o_result)
    );

endmodule

/* rtl/rtcl_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcl_in_stage: input register of the real-time clock
// Captures one request beat and holds it until the core executes it.
// ----------------------------------------------------------------------------
module rtcl_in_stage
    import rtcl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtcl_in_if.sink       i_item,
    input  logic          i_exec,
    output t_stage        o_stage
);

    logic       r_valid;
    t_op        r_op;
    logic [3:0] r_sel;
    logic [7:0] r_data;
    logic       accept;

    // take a new beat when empty or when the held one retires this cycle
    assign i_item.ready = !r_valid || i_exec;
    assign accept       = i_item.valid && i_item.ready;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_item.op);
            r_sel  <= i_item.select;
            r_data <= i_item.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.op    = r_op;
    assign o_stage.sel   = r_sel;
    assign o_stage.data  = r_data;

endmodule

/* rtl/rtcl_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcl_core: counters, shadow registers and read response register
// Executes one held beat per cycle unless a read is stalled: tick cascade,
// latch capture, register load or shadow read into the output register.
// ----------------------------------------------------------------------------
module rtcl_core
    import rtcl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_tps,
    input  t_stage        i_stage,
    output logic          o_exec,
    rtcl_out_if.source    o_result
);

    logic [7:0] r_sub_tick, n_sub_tick;
    logic [5:0] r_seconds,  n_seconds;
    logic [5:0] r_minutes,  n_minutes;
    logic [4:0] r_hours,    n_hours;
    logic [8:0] r_day,      n_day;
    logic       r_halted,   n_halted;
    logic       r_carry,    n_carry;
    logic       r_latch,    n_latch;
    logic [7:0] r_shadow [8];
    logic [7:0] n_shadow [8];
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic       out_free;
    logic       is_read;
    logic [8:0] sub_inc;
    logic       sec_done;

    // retire the held beat unless a read finds the output register full
    assign out_free = !r_out_valid || o_result.ready;
    assign is_read  = (i_stage.op == OP_READ);
    assign o_exec   = i_stage.valid && (!is_read || out_free);

    assign sub_inc  = {1'b0, r_sub_tick} + 9'd1;
    assign sec_done = (sub_inc >= {1'b0, i_tps});

    // next state of counters and shadows
    always_comb begin
        n_sub_tick = r_sub_tick;
        n_seconds  = r_seconds;
        n_minutes  = r_minutes;
        n_hours    = r_hours;
        n_day      = r_day;
        n_halted   = r_halted;
        n_carry    = r_carry;
        n_latch    = r_latch;
        for (int i = 0; i < 8; i++) begin
            n_shadow[i] = r_shadow[i];
        end

        if (o_exec) begin
            case (i_stage.op)
                OP_TICK: begin
                    if (!r_halted) begin
                        if (sec_done) begin
                            n_sub_tick = 8'd0;
                            // cascade seconds, minutes, hours and days
                            if (r_seconds != SEC_LAST) begin
                                n_seconds = r_seconds + 6'd1;
                            end else begin
                                n_seconds = 6'd0;
                                if (r_minutes != MIN_LAST) begin
                                    n_minutes = r_minutes + 6'd1;
                                end else begin
                                    n_minutes = 6'd0;
                                    if (r_hours != HOUR_LAST) begin
                                        n_hours = r_hours + 5'd1;
                                    end else begin
                                        n_hours = 5'd0;
                                        n_day   = r_day + 9'd1;
                                        if (r_day == DAY_LAST) begin
                                            n_carry = 1'b1;
                                        end
                                    end
                                end
                            end
                        end else begin
                            n_sub_tick = sub_inc[7:0];
                        end
                    end
                end
                OP_LATCH: begin
                    // capture on a rising bit 0
                    if (i_stage.data[0] && !r_latch) begin
                        n_shadow[0] = {2'b00, r_seconds};
                        n_shadow[1] = {2'b00, r_minutes};
                        n_shadow[2] = {3'b000, r_hours};
                        n_shadow[3] = r_day[7:0];
                        n_shadow[4] = {r_carry, r_halted, 5'b00000, r_day[8]};
                        n_shadow[5] = FILLER;
                        n_shadow[6] = FILLER;
                        n_shadow[7] = FILLER;
                    end
                    n_latch = i_stage.data[0];
                end
                OP_WRITE: begin
                    if (i_stage.sel[SEL_CLOCK_BIT]) begin
                        unique case (i_stage.sel[2:0])
                            REG_SEC: begin
                                n_shadow[0] = i_stage.data;
                                n_seconds   = mod60(i_stage.data);
                            end
                            REG_MIN: begin
                                n_shadow[1] = i_stage.data;
                                n_minutes   = mod60(i_stage.data);
                            end
                            REG_HOUR: begin
                                n_shadow[2] = i_stage.data;
                                n_hours     = mod24(i_stage.data);
                            end
                            REG_DAY_LO: begin
                                n_shadow[3] = i_stage.data;
                                n_day       = {r_day[8], i_stage.data};
                            end
                            REG_DAY_HI: begin
                                n_shadow[4] = i_stage.data;
                                n_day       = {i_stage.data[0], r_day[7:0]};
                                n_halted    = i_stage.data[6];
                                n_carry     = i_stage.data[7];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // hold clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_tick <= '0;
            r_seconds  <= '0;
            r_minutes  <= '0;
            r_hours    <= '0;
            r_day      <= '0;
            r_halted   <= 1'b0;
            r_carry    <= 1'b0;
            r_latch    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_shadow[i] <= '0;
            end
        end else begin
            r_sub_tick <= n_sub_tick;
            r_seconds  <= n_seconds;
            r_minutes  <= n_minutes;
            r_hours    <= n_hours;
            r_day      <= n_day;
            r_halted   <= n_halted;
            r_carry    <= n_carry;
            r_latch    <= n_latch;
            for (int i = 0; i < 8; i++) begin
                r_shadow[i] <= n_shadow[i];
            end
        end
    end

    // output register: load on a read, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_exec && is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_exec && is_read) begin
            r_out_data <= r_shadow[i_stage.sel[2:0]];
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out_data;

endmodule

/* sim/rtc_counter_with_latch_registers_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_counter_with_latch_registers_top_tb: self-checking bench of the RTC
// Drives tick, latch, write and read beats into the clock. A predictor of
// the counters, the latch and the shadow bytes runs in step with every
// accepted beat. Each read answer is compared with the oldest predicted
// byte. A short stimulus table opens the run. Random phases follow, each at
// its own tick rate and with one of three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module rtc_counter_with_latch_registers_top_tb;
    import rtcl_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 6;
    localparam int PHASE_BEATS     = 213;
    localparam int DIR_ROWS        = 26;
    localparam int RATE_SWITCH_ROW = 13;
    localparam logic [7:0] SEC_WRAP  = 8'd60;
    localparam logic [7:0] MIN_WRAP  = 8'd60;
    localparam logic [7:0] HOUR_WRAP = 8'd24;

    typedef struct {
        t_op        op;
        logic [3:0] sel;
        logic [7:0] data;
        bit         fixed;   // answer typed in below
        logic [7:0] want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_data;

    rtcl_in_if  item_if ();
    rtcl_out_if result_if ();

    rtc_counter_with_latch_registers_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // predicted clock state
    logic [7:0] m_rate;
    logic [7:0] m_sub;
    logic [7:0] m_sec;
    logic [7:0] m_min;
    logic [7:0] m_hour;
    logic [8:0] m_day;
    logic       m_halt;
    logic       m_carry;
    logic       m_latch;
    logic [7:0] m_shadow [8];

    logic [7:0] pending_reads [$];

    int fail_count    = 0;
    int reads_checked = 0;
    int beats_sent    = 0;
    int rates_used    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    t_stim_row dir_rows [DIR_ROWS] = '{
        '{OP_READ,  4'h0, 8'h00, 1'b1, 8'h00},  // fresh from reset
        '{OP_READ,  4'hF, 8'h00, 1'b1, 8'h00},  // filler slot before any latch
        '{OP_TICK,  4'h0, 8'h00, 1'b0, 8'h00},
        '{OP_WRITE, 4'h8, 8'hFF, 1'b0, 8'h00},
        '{OP_READ,  4'h8, 8'h00, 1'b1, 8'hFF},
        '{OP_WRITE, 4'h9, 8'h3B, 1'b0, 8'h00},
        '{OP_WRITE, 4'hA, 8'h17, 1'b0, 8'h00},
        '{OP_WRITE, 4'hB, 8'hFF, 1'b0, 8'h00},
        '{OP_WRITE, 4'hC, 8'h01, 1'b0, 8'h00},
        '{OP_WRITE, 4'h0, 8'h00, 1'b0, 8'h00},  // clock bit clear: ignored
        '{OP_WRITE, 4'hD, 8'h55, 1'b0, 8'h00},  // filler slot: ignored
        '{OP_READ,  4'h5, 8'h00, 1'b1, 8'h00},
        '{OP_WRITE, 4'h8, 8'h3B, 1'b0, 8'h00},
        '{OP_TICK,  4'h0, 8'h00, 1'b0, 8'h00},  // full cascade, day wraps
        '{OP_LATCH, 4'h0, 8'h00, 1'b0, 8'h00},
        '{OP_LATCH, 4'h0, 8'h01, 1'b0, 8'h00},
        '{OP_READ,  4'h3, 8'h00, 1'b0, 8'h00},
        '{OP_READ,  4'h4, 8'h00, 1'b0, 8'h00},
        '{OP_READ,  4'h7, 8'h00, 1'b1, 8'hFF},
        '{OP_WRITE, 4'hC, 8'hC0, 1'b0, 8'h00},
        '{OP_TICK,  4'h0, 8'h00, 1'b0, 8'h00},  // halted: no change
        '{OP_LATCH, 4'h0, 8'hFE, 1'b0, 8'h00},
        '{OP_LATCH, 4'h0, 8'hFF, 1'b0, 8'h00},
        '{OP_READ,  4'h0, 8'h00, 1'b0, 8'h00},
        '{OP_READ,  4'hC, 8'h00, 1'b0, 8'h00},
        '{OP_WRITE, 4'hC, 8'h00, 1'b0, 8'h00}
    };

    // clear the predicted state as reset does
    function automatic void clock_reset_state();
        m_rate  = TPS_RESET;
        m_sub   = '0;
        m_sec   = '0;
        m_min   = '0;
        m_hour  = '0;
        m_day   = '0;
        m_halt  = 1'b0;
        m_carry = 1'b0;
        m_latch = 1'b0;
        for (int i = 0; i < 8; i++) m_shadow[i] = '0;
    endfunction

    // cascade one completed second through minutes, hours and days
    function automatic void bump_second();
        m_sec = m_sec + 8'd1;
        if (m_sec < SEC_WRAP) return;
        m_sec = '0;
        m_min = m_min + 8'd1;
        if (m_min < MIN_WRAP) return;
        m_min = '0;
        m_hour = m_hour + 8'd1;
        if (m_hour < HOUR_WRAP) return;
        m_hour = '0;
        if (m_day == 9'd511) m_carry = 1'b1;
        m_day = m_day + 9'd1;
    endfunction

    // apply one beat to the predicted clock; returns 1 when a read answers
    function automatic bit clock_model_step(input t_op op, input logic [3:0] sel,
                                            input logic [7:0] d, output logic [7:0] rd);
        rd = '0;
        case (op)
            OP_TICK: begin
                if (!m_halt) begin
                    if ({1'b0, m_sub} + 9'd1 >= {1'b0, m_rate}) begin
                        m_sub = '0;
                        bump_second();
                    end else begin
                        m_sub = m_sub + 8'd1;
                    end
                end
            end
            OP_LATCH: begin
                if (d[0] && !m_latch) begin
                    m_shadow[REG_SEC]    = m_sec;
                    m_shadow[REG_MIN]    = m_min;
                    m_shadow[REG_HOUR]   = m_hour;
                    m_shadow[REG_DAY_LO] = m_day[7:0];
                    m_shadow[REG_DAY_HI] = {m_carry, m_halt, 5'd0, m_day[8]};
                    for (int i = 5; i < 8; i++) m_shadow[i] = FILLER;
                end
                m_latch = d[0];
            end
            OP_WRITE: begin
                if (sel[SEL_CLOCK_BIT]) begin
                    case (sel[2:0])
                        REG_SEC: begin
                            m_shadow[REG_SEC] = d;
                            m_sec = d % SEC_WRAP;
                        end
                        REG_MIN: begin
                            m_shadow[REG_MIN] = d;
                            m_min = d % MIN_WRAP;
                        end
                        REG_HOUR: begin
                            m_shadow[REG_HOUR] = d;
                            m_hour = d % HOUR_WRAP;
                        end
                        REG_DAY_LO: begin
                            m_shadow[REG_DAY_LO] = d;
                            m_day[7:0] = d;
                        end
                        REG_DAY_HI: begin
                            m_shadow[REG_DAY_HI] = d;
                            m_day[8] = d[0];
                            m_halt   = d[6];
                            m_carry  = d[7];
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                rd = m_shadow[sel[2:0]];
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("rtc_counter_with_latch_registers_top verification failed");
        $finish;
    end

    // response side: random back-pressure, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // check each answer beat against the oldest predicted byte
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_reads.size() == 0) begin
                $error("read_data: no read outstanding, got %02h", result_if.read_data);
                fail_count++;
            end else begin
                logic [7:0] want;
                want = pending_reads.pop_front();
                reads_checked++;
                if (result_if.read_data !== want) begin
                    $error("read_data: expected %02h, got %02h", want, result_if.read_data);
                    fail_count++;
                end
            end
        end
    end

    // offer one beat, predict it when taken; entered and left at a falling edge
    task automatic send_beat(input t_op op, input logic [3:0] sel, input logic [7:0] d,
                             input bit fixed, input logic [7:0] want);
        logic [7:0] rd;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.op     <= op;
        item_if.select <= sel;
        item_if.data   <= d;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        beats_sent++;
        if (clock_model_step(op, sel, d, rd)) pending_reads.push_back(fixed ? want : rd);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every predicted answer, then, if asked, let the block settle
    task automatic drain_reads(input bit settle);
        item_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_reads.size() != 0) @(negedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_tick_rate(input logic [7:0] rate);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rate;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        m_rate = rate;
        rates_used++;
    endtask

    // mostly well-formed clock traffic, with some noise
    task automatic random_traffic(input int n_beats);
        int k;
        int pick;
        logic [2:0] slot;
        logic [7:0] d;
        for (k = 0; k < n_beats; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_beat(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
            end else if (pick < 50) begin
                // latch pair: drop bit 0, then raise it
                send_beat(OP_LATCH, 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)) & 8'hFE, 1'b0, 8'h00);
                send_beat(OP_LATCH, 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)) | 8'h01, 1'b0, 8'h00);
                k++;
            end else if (pick < 70) begin
                send_beat(OP_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
            end else if (pick < 90) begin
                slot = 3'($urandom_range(0, 4));
                if ($urandom_range(0, 1)) begin
                    d = 8'($urandom_range(0, 255));
                end else begin
                    // load near the top so the cascade rolls over soon
                    case (slot)
                        REG_SEC, REG_MIN: d = 8'd59;
                        REG_HOUR:         d = 8'd23;
                        REG_DAY_LO:       d = 8'hFF;
                        default:          d = 8'h01;
                    endcase
                end
                send_beat(OP_WRITE, {1'b1, slot}, d, 1'b0, 8'h00);
            end else begin
                send_beat(t_op'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)), 1'b0, 8'h00);
            end
        end
    endtask

    initial begin
        logic [7:0] rate;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.op      = OP_TICK;
        item_if.select  = '0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        clock_reset_state();

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; the rate drops to one tick per second halfway
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == RATE_SWITCH_ROW) begin
                drain_reads(1'b1);
                set_tick_rate(8'd1);
            end
            send_beat(dir_rows[r].op, dir_rows[r].sel, dir_rows[r].data,
                      dir_rows[r].fixed, dir_rows[r].want);
        end

        // random phases, each at its own rate and idle mix
        for (int p = 0; p < PHASES; p++) begin
            drain_reads(1'b1);
            case (p)
                0: rate = 8'd255;
                1: rate = 8'd1;
                3: rate = 8'd2;
                5: rate = TPS_RESET;
                default: rate = 8'($urandom_range(3, 254));
            endcase
            set_tick_rate(rate);
            case (p % 3)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // choke the response side while beats keep coming
            if (p == 2) hold_reqs++;
            if (p == 3) begin
                random_traffic(PHASE_BEATS / 2);
                drain_reads(1'b0);
                random_traffic(PHASE_BEATS - PHASE_BEATS / 2);
            end else begin
                random_traffic(PHASE_BEATS);
            end
        end

        drain_reads(1'b1);
        $display("Run covered %0d beats and %0d checked read answers over %0d tick rates,",
                 beats_sent, reads_checked, rates_used);
        $display("with 21/88, 88/21 and no idling plus a long response hold-off.");
        if (fail_count == 0 && pending_reads.size() == 0) begin
            $display("rtc_counter_with_latch_registers_top verification clean");
        end else begin
            $display("rtc_counter_with_latch_registers_top verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/rtcl_pkg.sv
rtl/rtcl_in_if.sv
rtl/rtcl_out_if.sv
rtl/rtcl_in_stage.sv
rtl/rtcl_core.sv
rtl/rtc_counter_with_latch_registers_top.sv
sim/rtc_counter_with_latch_registers_top_tb.sv
